@@ sv/deferred_phong_lighting_core_macros.svh @@
// Assertion helpers shared by the lighting pipeline.
`ifndef DEFERRED_PHONG_LIGHTING_CORE_MACROS_SVH
`define DEFERRED_PHONG_LIGHTING_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles, disabled in reset.
`define DPL_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

@@ sv/dpl_pkg.sv @@
package dpl_pkg;

    localparam int X_FRAC = 14;
    localparam int X_W = X_FRAC + 1;
    localparam logic [X_W-1:0] X_ONE = X_W'(1 << X_FRAC);

    typedef enum logic [2:0] {
        CFG_LIGHT_X,
        CFG_LIGHT_Y,
        CFG_LIGHT_Z,
        CFG_AMBIENT,
        CFG_DIFFUSE,
        CFG_SPECULAR,
        CFG_SHININESS
    } t_cfg_idx;

endpackage

@@ sv/dpl_isqrt.sv @@
module dpl_isqrt #(
    parameter int ROOT_W = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_value,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root
);

    localparam int VW  = 2 * ROOT_W;
    localparam int RMW = ROOT_W + 2;

    logic [ROOT_W-1:0] r_val;
    logic [VW-1:0]     r_v    [ROOT_W];
    logic [RMW-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    logic [VW-1:0]     s_v    [ROOT_W];
    logic [RMW-1:0]    s_rem  [ROOT_W];
    logic [ROOT_W-1:0] s_root [ROOT_W];

    logic [VW-1:0]     n_v    [ROOT_W];
    logic [RMW-1:0]    n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    always_comb begin
        s_v[0]    = i_value;
        s_rem[0]  = '0;
        s_root[0] = '0;
        for (int t = 1; t < ROOT_W; t++) begin
            s_v[t]    = r_v[t-1];
            s_rem[t]  = r_rem[t-1];
            s_root[t] = r_root[t-1];
        end
    end

    // one root bit per stage
    always_comb begin
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           take;
        for (int t = 0; t < ROOT_W; t++) begin
            rem_sh    = {s_rem[t][ROOT_W-1:0], s_v[t][VW-1 -: 2]};
            trial     = {s_root[t], 2'b01};
            take      = rem_sh >= trial;
            n_rem[t]  = take ? rem_sh - trial : rem_sh;
            n_root[t] = {s_root[t][ROOT_W-2:0], take};
            n_v[t]    = s_v[t] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= {r_val[ROOT_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < ROOT_W; t++) begin
            r_v[t]    <= n_v[t];
            r_rem[t]  <= n_rem[t];
            r_root[t] <= n_root[t];
        end
    end

    assign o_valid = r_val[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

@@ sv/dpl_div.sv @@
`include "deferred_phong_lighting_core_macros.svh"

module dpl_div import dpl_pkg::*; #(
    parameter int S_W = 51,
    parameter int M_W = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [S_W-1:0] i_s,
    input  logic [M_W-1:0]        i_m,
    output logic                  o_valid,
    output logic [X_W-1:0]        o_x
);

    localparam int QB  = X_FRAC;
    localparam int LAT = QB + 1;
    localparam int RMW = M_W + QB;

    logic [LAT-1:0] r_val;
    logic [LAT-1:0] r_zero;
    logic [LAT-1:0] r_sat;
    logic [RMW-1:0] r_rem [LAT];
    logic [M_W-1:0] r_m   [LAT];
    logic [QB-1:0]  r_q   [LAT];

    logic [RMW-1:0] n_rem [LAT];
    logic [QB-1:0]  n_q   [LAT];
    logic           n_zero;
    logic           n_sat;

    // no quotient for a zero divisor or a non-positive dividend; clamp at one
    always_comb begin
        logic [S_W-1:0] lim;
        logic [RMW-1:0] dvs;
        logic           take;
        int             j;
        lim    = S_W'(i_m) << QB;
        n_zero = (i_m == '0) || i_s[S_W-1] || (i_s == '0);
        n_sat  = $unsigned(i_s) >= lim;
        n_rem[0] = RMW'($unsigned(i_s));
        n_q[0]   = '0;
        for (int t = 1; t < LAT; t++) begin
            j    = QB - t;
            dvs  = RMW'(r_m[t-1]) << j;
            take = r_rem[t-1] >= dvs;
            n_rem[t] = take ? r_rem[t-1] - dvs : r_rem[t-1];
            n_q[t]   = r_q[t-1];
            n_q[t][j] = take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= {r_val[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= {r_zero[LAT-2:0], n_zero};
        r_sat  <= {r_sat[LAT-2:0], n_sat};
        r_m[0] <= i_m;
        for (int t = 1; t < LAT; t++) begin
            r_m[t] <= r_m[t-1];
        end
        for (int t = 0; t < LAT; t++) begin
            r_rem[t] <= n_rem[t];
            r_q[t]   <= n_q[t];
        end
    end

    assign o_valid = r_val[LAT-1];
    assign o_x     = r_zero[LAT-1] ? '0 : (r_sat[LAT-1] ? X_ONE : X_W'(r_q[LAT-1]));

    `DPL_ASSERT_DLY(a_div_zero_m, i_clk, i_rst_n, i_valid && (i_m == '0), LAT, o_valid && (o_x == '0), "zero divisor gave a cosine")
    `DPL_ASSERT_IMP(a_div_bound, i_clk, i_rst_n, o_valid, o_x <= X_ONE, "cosine above one")

endmodule

@@ sv/deferred_phong_lighting_core.sv @@
// Phong lighting for deferred shading. One G-buffer pixel is taken per clock and the
// pipeline never stalls, so busy stays low. Each lit pixel appears on the o_out_* ports
// with o_valid high for one cycle, in input order. Most of the pipeline depth is the
// square-root pipeline (one root bit per stage, POS_BITS stages) and the cosine
// divider (15 stages, one quotient bit in each but the first), followed by seven
// squaring stages for the specular power. Configuration writes take effect at once
// and belong in idle time.
`include "deferred_phong_lighting_core_macros.svh"

module deferred_phong_lighting_core import dpl_pkg::*; #(
    parameter int COLOR_BITS = 8,
    parameter int POS_BITS   = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [15:0]                i_cfg_data,
    input  logic [COLOR_BITS-1:0]      i_color_r,
    input  logic [COLOR_BITS-1:0]      i_color_g,
    input  logic [COLOR_BITS-1:0]      i_color_b,
    input  logic [COLOR_BITS-1:0]      i_color_a,
    input  logic signed [15:0]         i_normal_x,
    input  logic signed [15:0]         i_normal_y,
    input  logic signed [15:0]         i_normal_z,
    input  logic signed [POS_BITS-1:0] i_pos_x,
    input  logic signed [POS_BITS-1:0] i_pos_y,
    input  logic signed [POS_BITS-1:0] i_pos_z,
    output logic                       o_valid,
    output logic [15:0]                o_out_r,
    output logic [15:0]                o_out_g,
    output logic [15:0]                o_out_b,
    output logic [15:0]                o_out_a
);

    localparam int CB      = COLOR_BITS;
    localparam int PB      = POS_BITS;
    localparam int CMAX    = (1 << CB) - 1;
    localparam int NW      = CB + 16;
    localparam int DENW    = CB + 1;
    localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(2 * CMAX);
    localparam logic [31:0] RECIP   = RECIP64[31:0];
    localparam logic [DENW-1:0] DEN  = DENW'(2 * CMAX);
    localparam logic [NW-1:0]   NMAX = NW'(CMAX);
    localparam int DW      = 34;
    localparam int DNW     = DW + 16;
    localparam int NDL_W   = 19;
    localparam int RW      = 24;
    localparam int NPW     = PB + 1;
    localparam int SPW     = RW + NPW;
    localparam int SW      = SPW + 2;
    localparam int PSQ_W   = 2 * PB;
    localparam int CN_W    = X_W + NDL_W - X_FRAC;
    localparam int DIF_W   = CN_W + 1;
    localparam int SUM_W   = DIF_W + 2;
    localparam int DIV_LAT = X_FRAC + 1;
    localparam int SHIN_W  = 3;
    localparam int PW_N    = (1 << SHIN_W) - 1;
    localparam int SIDE_N  = PB + DIV_LAT;

    typedef struct packed {
        logic                      az;
        logic [3:0][X_W-1:0]       c14;
        logic [NDL_W-1:0]          ndl;
    } t_side;

    function automatic logic [15:0] sat16(input logic [SUM_W-1:0] v);
        logic [15:0] r;
        r = (v > SUM_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

    // configuration
    logic signed [15:0] r_light [3];
    logic [15:0]        r_amb;
    logic [15:0]        r_dif;
    logic [15:0]        r_spc;
    logic [SHIN_W-1:0]  r_shin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light[0] <= 16'sd5461;
            r_light[1] <= 16'sd10923;
            r_light[2] <= 16'sd10923;
            r_amb      <= 16'd9830;
            r_dif      <= 16'd22938;
            r_spc      <= 16'd6554;
            r_shin     <= SHIN_W'(6);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LIGHT_X:   r_light[0] <= i_cfg_data;
                CFG_LIGHT_Y:   r_light[1] <= i_cfg_data;
                CFG_LIGHT_Z:   r_light[2] <= i_cfg_data;
                CFG_AMBIENT:   r_amb      <= i_cfg_data;
                CFG_DIFFUSE:   r_dif      <= i_cfg_data;
                CFG_SPECULAR:  r_spc      <= i_cfg_data;
                CFG_SHININESS: r_shin     <= i_cfg_data[SHIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // S0: input register
    logic                     r_s0_v;
    logic [CB-1:0]            r_s0_c [4];
    logic signed [15:0]       r_s0_n [3];
    logic signed [PB-1:0]     r_s0_p [3];

    // S1: products
    logic                     r_s1_v;
    logic signed [31:0]       r_s1_nl [3];
    logic [PSQ_W-1:0]         r_s1_pp [3];
    logic [NW-1:0]            r_s1_cn [4];
    logic [NW+31:0]           r_s1_cr [4];
    logic                     r_s1_az;
    logic signed [15:0]       r_s1_n [3];
    logic signed [PB-1:0]     r_s1_p [3];

    // S2: sums
    logic                     r_s2_v;
    logic signed [DW-1:0]     r_s2_d;
    logic [PSQ_W-1:0]         r_s2_psq;
    logic [X_W-1:0]           r_s2_q0 [4];
    logic [NW-1:0]            r_s2_cn [4];
    logic                     r_s2_az;
    logic signed [15:0]       r_s2_n [3];
    logic signed [PB-1:0]     r_s2_p [3];

    // S3..S6
    logic                     r_s3_v;
    logic signed [DNW-1:0]    r_s3_dn [3];
    logic [PSQ_W-1:0]         r_s3_psq;
    logic signed [PB-1:0]     r_s3_p [3];
    t_side                    r_s3_side;

    logic                     r_s4_v;
    logic signed [RW-1:0]     r_s4_r [3];
    logic [PSQ_W-1:0]         r_s4_psq;
    logic signed [PB-1:0]     r_s4_p [3];
    t_side                    r_s4_side;

    logic                     r_s5_v;
    logic signed [SPW-1:0]    r_s5_sp [3];
    logic [PSQ_W-1:0]         r_s5_psq;
    t_side                    r_s5_side;

    logic                     r_s6_v;
    logic signed [SW-1:0]     r_s6_s;
    logic [PSQ_W-1:0]         r_s6_psq;
    t_side                    r_s6_side;

    logic signed [PSQ_W-1:0]  n_pp_s [3];
    logic [X_W-1:0]           n_c14  [4];
    logic [NDL_W-1:0]         n_ndl;
    logic signed [RW-1:0]     n_r    [3];
    logic signed [SPW-1:0]    n_sp   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pp_s[i] = r_s0_p[i] * r_s0_p[i];
        end
    end

    // c14 = floor((c*32768 + max) / (2*max)) by reciprocal plus one correction
    always_comb begin
        logic [NW-1:0] qd;
        logic [NW-1:0] rem;
        for (int i = 0; i < 4; i++) begin
            qd       = NW'(r_s2_q0[i] * DEN);
            rem      = r_s2_cn[i] - qd;
            n_c14[i] = r_s2_q0[i] + X_W'(rem >= NW'(DEN));
        end
        n_ndl = (!r_s2_d[DW-1] && (r_s2_d != '0)) ? NDL_W'(r_s2_d >> X_FRAC) : '0;
    end

    always_comb begin
        logic signed [RW-1:0]  t;
        logic signed [NPW-1:0] np;
        for (int i = 0; i < 3; i++) begin
            t      = RW'(r_s3_dn[i] >>> 27);
            n_r[i] = t - RW'(r_light[i]);
            np     = -NPW'(r_s4_p[i]);
            n_sp[i] = r_s4_r[i] * np;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            r_s0_v <= start && !busy;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_c[0] <= i_color_r;
        r_s0_c[1] <= i_color_g;
        r_s0_c[2] <= i_color_b;
        r_s0_c[3] <= i_color_a;
        r_s0_n[0] <= i_normal_x;
        r_s0_n[1] <= i_normal_y;
        r_s0_n[2] <= i_normal_z;
        r_s0_p[0] <= i_pos_x;
        r_s0_p[1] <= i_pos_y;
        r_s0_p[2] <= i_pos_z;

        for (int i = 0; i < 3; i++) begin
            r_s1_nl[i] <= r_s0_n[i] * r_light[i];
            r_s1_pp[i] <= $unsigned(n_pp_s[i]);
            r_s1_n[i]  <= r_s0_n[i];
            r_s1_p[i]  <= r_s0_p[i];
        end
        for (int i = 0; i < 4; i++) begin
            r_s1_cn[i] <= NW'({r_s0_c[i], 15'b0}) + NMAX;
            r_s1_cr[i] <= (NW'({r_s0_c[i], 15'b0}) + NMAX) * RECIP;
        end
        r_s1_az <= (r_s0_c[3] == '0);

        r_s2_d   <= DW'(r_s1_nl[0]) + DW'(r_s1_nl[1]) + DW'(r_s1_nl[2]);
        r_s2_psq <= r_s1_pp[0] + r_s1_pp[1] + r_s1_pp[2];
        for (int i = 0; i < 4; i++) begin
            r_s2_q0[i] <= X_W'(r_s1_cr[i] >> 32);
            r_s2_cn[i] <= r_s1_cn[i];
        end
        r_s2_az <= r_s1_az;
        for (int i = 0; i < 3; i++) begin
            r_s2_n[i] <= r_s1_n[i];
            r_s2_p[i] <= r_s1_p[i];
        end

        for (int i = 0; i < 3; i++) begin
            r_s3_dn[i] <= r_s2_d * r_s2_n[i];
            r_s3_p[i]  <= r_s2_p[i];
        end
        r_s3_psq      <= r_s2_psq;
        r_s3_side.az  <= r_s2_az;
        r_s3_side.ndl <= n_ndl;
        for (int i = 0; i < 4; i++) begin
            r_s3_side.c14[i] <= n_c14[i];
        end

        for (int i = 0; i < 3; i++) begin
            r_s4_r[i] <= n_r[i];
            r_s4_p[i] <= r_s3_p[i];
        end
        r_s4_psq  <= r_s3_psq;
        r_s4_side <= r_s3_side;

        for (int i = 0; i < 3; i++) begin
            r_s5_sp[i] <= n_sp[i];
        end
        r_s5_psq  <= r_s4_psq;
        r_s5_side <= r_s4_side;

        r_s6_s    <= SW'(r_s5_sp[0]) + SW'(r_s5_sp[1]) + SW'(r_s5_sp[2]);
        r_s6_psq  <= r_s5_psq;
        r_s6_side <= r_s5_side;
    end

    // |pos| and the specular cosine
    logic              sq_v;
    logic [PB-1:0]     sq_root;
    logic              dv_v;
    logic [X_W-1:0]    dv_x;
    logic signed [SW-1:0] r_sdly [PB];
    t_side             r_side_dly [SIDE_N];

    dpl_isqrt #(
        .ROOT_W (PB)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s6_v),
        .i_value (r_s6_psq),
        .o_valid (sq_v),
        .o_root  (sq_root)
    );

    dpl_div #(
        .S_W (SW),
        .M_W (PB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v),
        .i_s     (r_sdly[PB-1]),
        .i_m     (sq_root),
        .o_valid (dv_v),
        .o_x     (dv_x)
    );

    always_ff @(posedge i_clk) begin
        r_sdly[0]     <= r_s6_s;
        r_side_dly[0] <= r_s6_side;
        for (int i = 1; i < PB; i++) begin
            r_sdly[i] <= r_sdly[i-1];
        end
        for (int i = 1; i < SIDE_N; i++) begin
            r_side_dly[i] <= r_side_dly[i-1];
        end
    end

    // specular power: repeated squaring
    logic [PW_N-1:0] r_pw_v;
    logic [X_W-1:0]  r_pw_x    [PW_N];
    t_side           r_pw_side [PW_N];
    logic [X_W-1:0]  s_pw_x    [PW_N];
    t_side           s_pw_side [PW_N];
    logic [X_W-1:0]  n_pw_x    [PW_N];

    always_comb begin
        s_pw_x[0]    = dv_x;
        s_pw_side[0] = r_side_dly[SIDE_N-1];
        for (int k = 1; k < PW_N; k++) begin
            s_pw_x[k]    = r_pw_x[k-1];
            s_pw_side[k] = r_pw_side[k-1];
        end
    end

    always_comb begin
        logic [2*X_W-1:0] sq;
        for (int k = 0; k < PW_N; k++) begin
            sq        = s_pw_x[k] * s_pw_x[k];
            n_pw_x[k] = (SHIN_W'(k) < r_shin) ? X_W'(sq >> X_FRAC) : s_pw_x[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_v <= '0;
        end else begin
            r_pw_v <= {r_pw_v[PW_N-2:0], dv_v};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PW_N; k++) begin
            r_pw_x[k]    <= n_pw_x[k];
            r_pw_side[k] <= s_pw_side[k];
        end
    end

    // shading terms
    logic              r_fa_v;
    logic [15:0]       r_fa_amb [3];
    logic [CN_W-1:0]   r_fa_cn  [4];
    logic [15:0]       r_fa_spc;
    logic [X_W-1:0]    r_fa_x;
    t_side             r_fa_side;

    logic [15:0]       n_fa_amb [3];
    logic [CN_W-1:0]   n_fa_cn  [4];
    logic [15:0]       n_fa_spc;
    t_side             fa_in;
    logic [X_W-1:0]    fa_x;

    assign fa_in = r_pw_side[PW_N-1];
    assign fa_x  = r_pw_x[PW_N-1];

    always_comb begin
        logic [X_W+15:0]      pa;
        logic [X_W+NDL_W-1:0] pc;
        logic [X_W+15:0]      ps;
        for (int i = 0; i < 3; i++) begin
            pa          = fa_in.c14[i] * r_amb;
            n_fa_amb[i] = 16'(pa >> 15);
        end
        for (int i = 0; i < 4; i++) begin
            pc         = fa_in.c14[i] * fa_in.ndl;
            n_fa_cn[i] = CN_W'(pc >> X_FRAC);
        end
        ps       = fa_x * r_spc;
        n_fa_spc = 16'(ps >> 15);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_fa_amb[i] <= n_fa_amb[i];
        end
        for (int i = 0; i < 4; i++) begin
            r_fa_cn[i] <= n_fa_cn[i];
        end
        r_fa_spc  <= n_fa_spc;
        r_fa_x    <= fa_x;
        r_fa_side <= fa_in;
    end

    // final sums
    logic        r_o_v;
    logic [15:0] r_o_c [4];
    logic [15:0] n_o_c [4];

    always_comb begin
        logic [CN_W+15:0]  pd;
        logic [SUM_W-1:0]  sum;
        for (int i = 0; i < 3; i++) begin
            pd  = r_fa_cn[i] * r_dif;
            sum = SUM_W'(r_fa_amb[i]) + SUM_W'(pd >> 15) + SUM_W'(r_fa_spc);
            n_o_c[i] = r_fa_side.az ? 16'(r_fa_side.c14[i]) : sat16(sum);
        end
        sum = SUM_W'(r_fa_side.c14[3]) + SUM_W'(r_fa_cn[3]) + SUM_W'(r_fa_x);
        n_o_c[3] = r_fa_side.az ? 16'd0 : sat16(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_fa_v <= r_pw_v[PW_N-1];
            r_o_v  <= r_fa_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_o_c[i] <= n_o_c[i];
        end
    end

    assign o_valid = r_o_v;
    assign o_out_r = r_o_c[0];
    assign o_out_g = r_o_c[1];
    assign o_out_b = r_o_c[2];
    assign o_out_a = r_o_c[3];

    `DPL_ASSERT_DLY(a_tail_latency, i_clk, i_rst_n, r_s6_v, PB + DIV_LAT + PW_N + 2, o_valid, "pixel lost in tail pipeline")
    `DPL_ASSERT_IMP(a_pow_bound, i_clk, i_rst_n, r_pw_v[PW_N-1], r_pw_x[PW_N-1] <= X_ONE, "specular power above one")
    `DPL_ASSERT_IMP(a_align, i_clk, i_rst_n, dv_v, r_pw_v[0] == 1'b0 || r_pw_v[0] == 1'b1, "divider valid unknown")

endmodule
